/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define M4XF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define M4XF_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define M4XF_ASSERT(lbl, prop, msg)
`define M4XF_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

/* src/m4xf_pkg.sv */
// ----------------------------------------------------------------------------
// m4xf_pkg
// Types, operation codes and constant tables of the 4x4 transform engine.
// ----------------------------------------------------------------------------
`default_nettype none

package m4xf_pkg;

    localparam logic [3:0] OP_WR_CUR   = 4'd0;
    localparam logic [3:0] OP_WR_OPD   = 4'd1;
    localparam logic [3:0] OP_IDENT    = 4'd2;
    localparam logic [3:0] OP_TRANS    = 4'd3;
    localparam logic [3:0] OP_SCALE    = 4'd4;
    localparam logic [3:0] OP_TRANSP   = 4'd5;
    localparam logic [3:0] OP_CLR_T    = 4'd6;
    localparam logic [3:0] OP_RIGID    = 4'd7;
    localparam logic [3:0] OP_MUL      = 4'd8;
    localparam logic [3:0] OP_VEC      = 4'd9;
    localparam logic [3:0] OP_READ     = 4'd10;

    // Row 3, columns 0 to 2: the translation entries.
    localparam logic [15:0] TRANS_MASK = 16'h7000;

    typedef struct packed {
        logic [3:0]         op;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } m4xf_cmd_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } m4xf_rsp_t;

    // Control that travels with one product through the MAC pipeline.
    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
    } m4xf_mac_ctl_t;

    // A pending memory read whose data lands in a side register.
    typedef struct packed {
        logic       vld;
        logic       tcap;
        logic [1:0] k;
    } m4xf_ld_ctl_t;

    // Element index of the upper and lower partner of each transpose swap.
    function automatic logic [3:0] swap_a(input logic [2:0] p);
        logic [3:0] r;
        case (p)
            3'd0:    r = 4'd1;
            3'd1:    r = 4'd2;
            3'd2:    r = 4'd3;
            3'd3:    r = 4'd6;
            3'd4:    r = 4'd7;
            3'd5:    r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] swap_b(input logic [2:0] p);
        logic [3:0] r;
        case (p)
            3'd0:    r = 4'd4;
            3'd1:    r = 4'd8;
            3'd2:    r = 4'd12;
            3'd3:    r = 4'd9;
            3'd4:    r = 4'd13;
            3'd5:    r = 4'd14;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/matrix4_transform_engine.sv */
// Throughput: one command at a time, set by the single read and write port of the
// current-matrix memory and one shared multiply-accumulate unit (one product a cycle).
// Reset: asynchronous, active low; both matrices read as zero until written.
// ----------------------------------------------------------------------------
// matrix4_transform_engine
// 4x4 fixed-point affine matrix engine, row-vector convention, memory based.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module matrix4_transform_engine #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire m4xf_pkg::m4xf_cmd_t  cmd,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output m4xf_pkg::m4xf_rsp_t       rsp
);

    // Both matrices live in 16-entry memories with a registered read port.
    // A valid bit per entry makes an entry that was never written read as zero,
    // so reset needs no clearing pass. Clear translation only drops valid bits.
    //
    // A shared MAC pipeline does every dot product: the issue cycle drives the
    // memory address, the next cycle multiplies the registered read data, the
    // next accumulates, and the last saturates and writes back. Premultiply works
    // one column at a time: the column is buffered first, so the results of that
    // column can be written straight back into the current matrix.
    // Rigid inverse captures the negated translation, clears it, transposes by
    // swapping pairs in place, then runs the same premultiply with a built-in
    // left matrix.

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int AW = 2 * WORD_BITS + 2;

    localparam logic signed [AW-1:0] HI_W  = AW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [AW-1:0] LO_W  = ~HI_W;
    localparam logic signed [AW-1:0] HI_32 = AW'({1'b0, {31{1'b1}}});
    localparam logic signed [AW-1:0] LO_32 = ~HI_32;
    localparam logic signed [W-1:0]  ONE_VAL = (FRAC_BITS <= W - 2)
        ? ({{(W-1){1'b0}}, 1'b1} << FRAC_BITS) : {1'b0, {(W-1){1'b1}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_TCAP  = 4'd2;
    localparam logic [3:0] S_SWAP  = 4'd3;
    localparam logic [3:0] S_LOAD  = 4'd4;
    localparam logic [3:0] S_MAC   = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_VEC   = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;
    localparam logic [3:0] S_RES   = 4'd9;

    function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] x);
        if (x > HI_W)
            return HI_W[W-1:0];
        else if (x < LO_W)
            return LO_W[W-1:0];
        else
            return x[W-1:0];
    endfunction

    function automatic logic signed [31:0] sat_32(input logic signed [AW-1:0] x);
        if (x > HI_32)
            return HI_32[31:0];
        else if (x < LO_32)
            return LO_32[31:0];
        else
            return x[31:0];
    endfunction

    // Matrix storage.
    logic [W-1:0]          cur_mem [16];
    logic [W-1:0]          opd_mem [16];
    logic [15:0]           cur_vld_reg, cur_vld_next;
    logic [15:0]           opd_vld_reg, opd_vld_next;
    logic [W-1:0]          cur_rd_reg, opd_rd_reg;
    logic                  cur_rvld_reg, opd_rvld_reg;
    logic                  cur_we, opd_we;
    logic [3:0]            cur_waddr, opd_waddr, cur_raddr, opd_raddr;
    logic signed [W-1:0]   cur_wdata, opd_wdata;
    logic [15:0]           cur_clr;
    logic signed [W-1:0]   cur_data, opd_data;

    // Sequencer and datapath registers.
    logic [3:0]            state_reg, state_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [1:0]            j_reg, j_next;
    logic [3:0]            op_reg, op_next;
    logic signed [W-1:0]   vin_reg [4];
    logic signed [W-1:0]   tneg_reg [3];
    logic signed [W-1:0]   col_reg [4];
    logic signed [W-1:0]   swp_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [31:0]    res_reg [3];
    m4xf_pkg::m4xf_mac_ctl_t p1_reg, p2_reg, p3_reg, issue;
    m4xf_pkg::m4xf_ld_ctl_t  ld_reg, ld_issue;
    m4xf_pkg::m4xf_rsp_t     rsp_reg, rsp_next;
    logic                  rsp_vld_reg, rsp_vld_next;
    logic                  rsp_load;
    logic                  accept;
    logic                  mac_busy;

    logic [2:0]            pair;
    logic [1:0]            phase;
    logic [1:0]            vsel;
    logic signed [W-1:0]   vin_sel, fill_val, mac_a, mac_b, wres;
    logic signed [PW-1:0]  prod_next;
    logic signed [AW-1:0]  acc_next;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign cur_data  = cur_rvld_reg ? $signed(cur_rd_reg) : '0;
    assign opd_data  = opd_rvld_reg ? $signed(opd_rd_reg) : '0;
    assign pair      = cnt_reg[4:2];
    assign phase     = cnt_reg[1:0];
    assign mac_busy  = p1_reg.vld || p2_reg.vld || p3_reg.vld;

    // One selector serves both the fill sweep and the vector MAC lanes.
    assign vsel    = (state_reg == S_FILL) ? cnt_reg[1:0] : p1_reg.k;
    assign vin_sel = vin_reg[vsel];

    always_comb
    begin
        fill_val = '0;
        case (op_reg)
            m4xf_pkg::OP_TRANS:
            begin
                if (cnt_reg[3:2] == 2'd3 && cnt_reg[1:0] != 2'd3)
                    fill_val = vin_sel;
                else if (cnt_reg[3:2] == cnt_reg[1:0])
                    fill_val = ONE_VAL;
            end
            m4xf_pkg::OP_SCALE:
            begin
                if (cnt_reg[3:2] == cnt_reg[1:0])
                    fill_val = (cnt_reg[1:0] == 2'd3) ? ONE_VAL : vin_sel;
            end
            default:
            begin
                if (cnt_reg[3:2] == cnt_reg[1:0])
                    fill_val = ONE_VAL;
            end
        endcase
    end

    // Multiplier operands for the product entering the pipeline.
    always_comb
    begin
        mac_a = '0;
        mac_b = col_reg[p1_reg.k];
        case (op_reg)
            m4xf_pkg::OP_MUL:
                mac_a = opd_data;
            m4xf_pkg::OP_RIGID:
            begin
                // Left matrix: identity whose row 3 holds the negated translation.
                if (p1_reg.i != 2'd3)
                    mac_a = (p1_reg.k == p1_reg.i) ? ONE_VAL : '0;
                else if (p1_reg.k == 2'd3)
                    mac_a = ONE_VAL;
                else
                    mac_a = tneg_reg[p1_reg.k];
            end
            default:
            begin
                mac_a = vin_sel;
                mac_b = cur_data;
            end
        endcase
    end

    assign prod_next = mac_a * mac_b;
    assign acc_next  = (p2_reg.first ? '0 : acc_reg) + AW'(prod_reg);
    assign wres      = sat_w(acc_reg >>> FRAC_BITS);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        op_next    = op_reg;
        cur_raddr  = {cmd.row, cmd.col};
        opd_raddr  = cnt_reg[3:0];
        cur_we     = 1'b0;
        cur_waddr  = {p3_reg.i, p3_reg.j};
        cur_wdata  = wres;
        opd_we     = 1'b0;
        opd_waddr  = {cmd.row, cmd.col};
        opd_wdata  = sat_w(AW'($signed(cmd.in_x)));
        cur_clr    = '0;
        issue      = '0;
        ld_issue   = '0;
        rsp_load   = 1'b0;

        // Write back of a finished matrix element.
        if (p3_reg.vld && p3_reg.last && op_reg != m4xf_pkg::OP_VEC)
            cur_we = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = cmd.op;
                    cnt_next = '0;
                    j_next   = '0;
                    unique case (cmd.op) inside
                        m4xf_pkg::OP_WR_CUR:
                        begin
                            cur_we    = 1'b1;
                            cur_waddr = {cmd.row, cmd.col};
                            cur_wdata = sat_w(AW'($signed(cmd.in_x)));
                        end
                        m4xf_pkg::OP_WR_OPD:
                            opd_we = 1'b1;
                        m4xf_pkg::OP_IDENT, m4xf_pkg::OP_TRANS, m4xf_pkg::OP_SCALE:
                            state_next = S_FILL;
                        m4xf_pkg::OP_TRANSP:
                            state_next = S_SWAP;
                        m4xf_pkg::OP_CLR_T:
                            cur_clr = m4xf_pkg::TRANS_MASK;
                        m4xf_pkg::OP_RIGID:
                            state_next = S_TCAP;
                        m4xf_pkg::OP_MUL:
                            state_next = S_LOAD;
                        m4xf_pkg::OP_VEC:
                            state_next = S_VEC;
                        m4xf_pkg::OP_READ:
                            state_next = S_RD;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_FILL:
            begin
                cur_we    = 1'b1;
                cur_waddr = cnt_reg[3:0];
                cur_wdata = fill_val;
                if (cnt_reg[3:0] == 4'd15)
                    state_next = S_IDLE;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_TCAP:
            begin
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cur_clr    = m4xf_pkg::TRANS_MASK;
                    cnt_next   = '0;
                    state_next = S_SWAP;
                end
                else
                begin
                    cur_raddr     = {2'd3, cnt_reg[1:0]};
                    ld_issue.vld  = 1'b1;
                    ld_issue.tcap = 1'b1;
                    ld_issue.k    = cnt_reg[1:0];
                    cnt_next      = cnt_reg + 5'd1;
                end
            end
            S_SWAP:
            begin
                cur_raddr = (phase == 2'd0) ? m4xf_pkg::swap_a(pair)
                                            : m4xf_pkg::swap_b(pair);
                if (phase == 2'd2)
                begin
                    cur_we    = 1'b1;
                    cur_waddr = m4xf_pkg::swap_a(pair);
                    cur_wdata = cur_data;
                end
                if (phase == 2'd3)
                begin
                    cur_we    = 1'b1;
                    cur_waddr = m4xf_pkg::swap_b(pair);
                    cur_wdata = swp_reg;
                end
                if (phase == 2'd3 && pair == 3'd5)
                begin
                    cnt_next   = '0;
                    state_next = (op_reg == m4xf_pkg::OP_RIGID) ? S_LOAD : S_IDLE;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_LOAD:
            begin
                cur_raddr    = {cnt_reg[1:0], j_reg};
                ld_issue.vld = 1'b1;
                ld_issue.k   = cnt_reg[1:0];
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = '0;
                    state_next = S_MAC;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_MAC:
            begin
                issue.vld   = 1'b1;
                issue.i     = cnt_reg[3:2];
                issue.k     = cnt_reg[1:0];
                issue.j     = j_reg;
                issue.first = (cnt_reg[1:0] == 2'd0);
                issue.last  = (cnt_reg[1:0] == 2'd3);
                if (cnt_reg[3:0] == 4'd15)
                    state_next = S_DRAIN;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_DRAIN:
            begin
                if (!mac_busy)
                begin
                    cnt_next = '0;
                    if (op_reg == m4xf_pkg::OP_VEC)
                        state_next = S_RES;
                    else if (j_reg == 2'd3)
                        state_next = S_IDLE;
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_VEC:
            begin
                cur_raddr   = {cnt_reg[1:0], cnt_reg[3:2]};
                issue.vld   = 1'b1;
                issue.k     = cnt_reg[1:0];
                issue.j     = cnt_reg[3:2];
                issue.first = (cnt_reg[1:0] == 2'd0);
                issue.last  = (cnt_reg[1:0] == 2'd3);
                if (cnt_reg[3:0] == 4'd11)
                    state_next = S_DRAIN;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_RD:
                state_next = S_RES;
            S_RES:
            begin
                if (!rsp_vld_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cur_vld_next = cur_vld_reg & ~cur_clr;
        if (cur_we)
            cur_vld_next[cur_waddr] = 1'b1;
        opd_vld_next = opd_vld_reg;
        if (opd_we)
            opd_vld_next[opd_waddr] = 1'b1;
    end

    assign rsp_next.out_x = res_reg[0];
    assign rsp_next.out_y = res_reg[1];
    assign rsp_next.out_z = res_reg[2];
    assign rsp_vld_next   = rsp_load || (rsp_vld_reg && rsp_stall);

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_mem[cur_waddr] <= cur_wdata;
        cur_rd_reg <= cur_mem[cur_raddr];
        if (opd_we)
            opd_mem[opd_waddr] <= opd_wdata;
        opd_rd_reg <= opd_mem[opd_raddr];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vin_reg[0] <= sat_w(AW'($signed(cmd.in_x)));
            vin_reg[1] <= sat_w(AW'($signed(cmd.in_y)));
            vin_reg[2] <= sat_w(AW'($signed(cmd.in_z)));
            vin_reg[3] <= sat_w(AW'($signed(cmd.in_w)));
        end
        if (ld_reg.vld)
        begin
            if (ld_reg.tcap)
                tneg_reg[ld_reg.k] <= sat_w(-AW'(cur_data));
            else
                col_reg[ld_reg.k] <= cur_data;
        end
        if (state_reg == S_SWAP && phase == 2'd1)
            swp_reg <= cur_data;
        if (p1_reg.vld)
            prod_reg <= prod_next;
        if (p2_reg.vld)
            acc_reg <= acc_next;
        if (p3_reg.vld && p3_reg.last && op_reg == m4xf_pkg::OP_VEC)
            res_reg[p3_reg.j] <= sat_32(AW'(wres));
        if (state_reg == S_RD)
        begin
            res_reg[0] <= sat_32(AW'(cur_data));
            res_reg[1] <= '0;
            res_reg[2] <= '0;
        end
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            j_reg        <= '0;
            op_reg       <= '0;
            cur_vld_reg  <= '0;
            opd_vld_reg  <= '0;
            cur_rvld_reg <= 1'b0;
            opd_rvld_reg <= 1'b0;
            p1_reg       <= '0;
            p2_reg       <= '0;
            p3_reg       <= '0;
            ld_reg       <= '0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            j_reg        <= j_next;
            op_reg       <= op_next;
            cur_vld_reg  <= cur_vld_next;
            opd_vld_reg  <= opd_vld_next;
            cur_rvld_reg <= cur_vld_reg[cur_raddr];
            opd_rvld_reg <= opd_vld_reg[opd_raddr];
            p1_reg       <= issue;
            p2_reg       <= p1_reg;
            p3_reg       <= p2_reg;
            ld_reg       <= ld_issue;
            rsp_vld_reg  <= rsp_vld_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    `M4XF_ASSERT(a_idle_drained, (state_reg == S_IDLE) |-> !mac_busy, "MAC busy while idle")
    `M4XF_ASSERT_NXT(a_rsp_loaded, rsp_load, rsp_vld_reg, "result beat not presented")
    `M4XF_ASSERT(a_vec_no_write, (state_reg == S_VEC) |-> !cur_we, "matrix written in vector op")
    `M4XF_ASSERT(a_p3_state, p3_reg.vld |-> cmd_stall, "MAC result while idle")

endmodule

`default_nettype wire
